@@ src/bpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared constants, codes and control structs of the band-pass FIR filter.
// ----------------------------------------------------------------------------
package bpf_pkg;

   localparam int TAPS   = 153;
   localparam int CENTER = 76;

   localparam int EFF_CENTER = (CENTER > TAPS - 1) ? TAPS - 1 : CENTER;
   localparam int LAG        = TAPS - 1 - EFF_CENTER;

   localparam int SMP_W  = 16;
   localparam int ACC_W  = 32;
   localparam int SHIFT  = 16;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int CIDX_W = (TAP_W > 8) ? TAP_W : 8;
   localparam int CNT_W  = 17;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [15:0] FRAME_LEN_RST = 16'd21600;

   typedef enum logic [1:0] {
      FUNC_COEF   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_PAD    = 2'd2,
      FUNC_START  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic rotate;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic run;
   } mac_ctl_type;

endpackage

@@ src/bandpass_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandpass_fir_filter
// Centered 153-tap FIR over a frame of samples, built as a ring of tap cells
// that rotates past one multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Sequence: a push that yields an output turns the ring once past the MAC,
//   drains the last product, then loads the output register.
// Flow: items without output never stall the input; a push with output
//   stalls it until its result loads, held off while the output is stalled.
// Reset: synchronous; clears the history, push count and control, sets
//   frame_length to 21600. Coefficients are not reset.
module bandpass_fir_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic signed [15:0] req_sample_in,
   input  logic [7:0]  req_coef_index,
   input  logic signed [15:0] req_coef_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_sample_out,
   output logic [15:0] rsp_out_index,
   output logic        rsp_frame_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int TAPS  = bpf_pkg::TAPS;
   localparam int TAP_W = bpf_pkg::TAP_W;
   localparam int CNT_W = bpf_pkg::CNT_W;
   localparam int SMP_W = bpf_pkg::SMP_W;

   bpf_pkg::state_type state_ff, state_in;
   logic [TAP_W-1:0]   rot_ff, rot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]        flen_ff, flen_in;
   logic [15:0]        idx_ff, idx_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_smp_ff, rsp_smp_in;
   logic [15:0]        rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in;

   bpf_pkg::func_type     func;
   bpf_pkg::cell_ctl_type cell_ctl;
   bpf_pkg::mac_ctl_type  mac_ctl;
   logic                  accept;
   logic                  is_push;
   logic                  is_coef;
   logic                  emit;
   logic                  load;
   logic [CNT_W-1:0]      cnt_nx;
   logic [CNT_W-1:0]      idx_nx;
   logic signed [SMP_W-1:0] push_val;
   logic [bpf_pkg::ACC_W-1:0] acc;

   logic signed [SMP_W-1:0] smp [TAPS];
   logic signed [SMP_W-1:0] cf  [TAPS];

   always_comb begin
      func    = bpf_pkg::func_type'(req_func);
      accept  = req_valid && (state_ff == bpf_pkg::ST_IDLE);
      is_push = 1'b0;
      is_coef = 1'b0;
      cell_ctl.clear = 1'b0;
      push_val = '0;
      unique case (func)
         bpf_pkg::FUNC_COEF:   is_coef = accept;
         bpf_pkg::FUNC_SAMPLE: begin
            is_push  = accept;
            push_val = req_sample_in;
         end
         bpf_pkg::FUNC_PAD:    is_push = accept;
         bpf_pkg::FUNC_START:  cell_ctl.clear = accept;
         default:              is_push = 1'b0;
      endcase

      cnt_nx = (cnt_ff == bpf_pkg::CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
      idx_nx = cnt_nx - CNT_W'(bpf_pkg::LAG) - CNT_W'(1);
      emit   = (cnt_nx > CNT_W'(bpf_pkg::LAG)) && (idx_nx < {1'b0, flen_ff});

      cell_ctl.push   = is_push;
      cell_ctl.rotate = (state_ff == bpf_pkg::ST_RUN);
      mac_ctl.run     = (state_ff == bpf_pkg::ST_RUN);
      mac_ctl.clear   = 1'b0;

      flen_in  = csr_wr_en ? csr_wr_data : flen_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      rot_in   = rot_ff;
      state_in = state_ff;
      load     = 1'b0;

      if (cell_ctl.clear) begin
         cnt_in = '0;
      end else if (is_push) begin
         cnt_in = cnt_nx;
      end

      unique case (state_ff)
         bpf_pkg::ST_IDLE: begin
            if (is_push && emit) begin
               state_in      = bpf_pkg::ST_RUN;
               rot_in        = '0;
               mac_ctl.clear = 1'b1;
               idx_in        = idx_nx[15:0];
               last_in       = ((idx_nx + CNT_W'(1)) == {1'b0, flen_ff});
            end
         end
         bpf_pkg::ST_RUN: begin
            // one full turn brings every cell back home
            if (rot_ff == TAP_W'(TAPS - 1)) begin
               state_in = bpf_pkg::ST_DRAIN;
            end else begin
               rot_in = rot_ff + TAP_W'(1);
            end
         end
         bpf_pkg::ST_DRAIN: state_in = bpf_pkg::ST_DONE;
         bpf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = bpf_pkg::ST_IDLE;
            end
         end
         default: state_in = bpf_pkg::ST_IDLE;
      endcase

      rsp_smp_in  = rsp_smp_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_smp_in   = acc[bpf_pkg::SHIFT +: 16];
         rsp_idx_in   = idx_ff;
         rsp_last_in  = last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpf_pkg::ST_IDLE;
         rot_ff       <= '0;
         cnt_ff       <= '0;
         flen_ff      <= bpf_pkg::FRAME_LEN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         cnt_ff       <= cnt_in;
         flen_ff      <= flen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      rsp_smp_ff  <= rsp_smp_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // cell j holds history sample j (0 newest) and coefficient TAPS-1-j
   for (genvar j = 0; j < TAPS; j++) begin : g_cell
      localparam int NXT = (j + 1) % TAPS;
      logic signed [SMP_W-1:0] left;
      logic                    we;

      if (j == 0) begin : g_head
         assign left = push_val;
      end else begin : g_body
         assign left = smp[j-1];
      end

      assign we = is_coef && (bpf_pkg::CIDX_W'(req_coef_index) ==
                              bpf_pkg::CIDX_W'(TAPS - 1 - j));

      bpf_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .coef_we      (we),
         .coef_wdata   (req_coef_value),
         .left_sample  (left),
         .right_sample (smp[NXT]),
         .right_coef   (cf[NXT]),
         .sample       (smp[j]),
         .coef         (cf[j])
      );
   end

   bpf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (smp[0]),
      .coef   (cf[0]),
      .acc    (acc)
   );

   assign req_stall      = (state_ff != bpf_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_smp_ff;
   assign rsp_out_index  = rsp_idx_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

@@ src/bpf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_cell
// One tap cell: holds a history sample and its coefficient. Clears the sample
// on a start, shifts in from the left on a push, rotates both from the right.
// ----------------------------------------------------------------------------
module bpf_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  bpf_pkg::cell_ctl_type          ctl,
   input  logic                           coef_we,
   input  logic signed [bpf_pkg::SMP_W-1:0] coef_wdata,
   input  logic signed [bpf_pkg::SMP_W-1:0] left_sample,
   input  logic signed [bpf_pkg::SMP_W-1:0] right_sample,
   input  logic signed [bpf_pkg::SMP_W-1:0] right_coef,
   output logic signed [bpf_pkg::SMP_W-1:0] sample,
   output logic signed [bpf_pkg::SMP_W-1:0] coef
);

   logic signed [bpf_pkg::SMP_W-1:0] sample_ff, sample_in;
   logic signed [bpf_pkg::SMP_W-1:0] coef_ff, coef_in;

   always_comb begin
      sample_in = sample_ff;
      coef_in   = coef_ff;
      if (ctl.clear) begin
         sample_in = '0;
      end else if (ctl.push) begin
         sample_in = left_sample;
      end else if (ctl.rotate) begin
         sample_in = right_sample;
      end
      if (ctl.rotate) begin
         coef_in = right_coef;
      end else if (coef_we) begin
         coef_in = coef_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign sample = sample_ff;
   assign coef   = coef_ff;

endmodule

@@ src/bpf_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_mac
// Multiply-accumulate at the head of the ring: registered 16x16 product,
// then a wrapping 32-bit accumulate.
// ----------------------------------------------------------------------------
module bpf_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  bpf_pkg::mac_ctl_type             ctl,
   input  logic signed [bpf_pkg::SMP_W-1:0] sample,
   input  logic signed [bpf_pkg::SMP_W-1:0] coef,
   output logic        [bpf_pkg::ACC_W-1:0] acc
);

   logic signed [bpf_pkg::ACC_W-1:0] prod_ff, prod_in;
   logic                             prod_vld_ff, prod_vld_in;
   logic        [bpf_pkg::ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      prod_in     = bpf_pkg::ACC_W'(sample) * bpf_pkg::ACC_W'(coef);
      prod_vld_in = ctl.run;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ src/bpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_checker
// Port-level checks of the band-pass FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module bpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [15:0] rsp_sample_out,
   input logic [15:0] rsp_out_index,
   input logic        rsp_frame_last
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) &&
                                 $stable(rsp_out_index) && $stable(rsp_frame_last))
      else $error("stalled result item changed");

   // coefficient writes and frame starts never busy the block
   a_no_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_func == bpf_pkg::FUNC_COEF || req_func == bpf_pkg::FUNC_START)
      |=> !req_stall)
      else $error("block busy after an item without output");

   // a result only appears at the end of a busy period
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without a computation");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not idle the block");

endmodule

bind bandpass_fir_filter bpf_checker u_bpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_out_index  (rsp_out_index),
   .rsp_frame_last (rsp_frame_last)
);

@@ tb/tb_bandpass_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bandpass_fir_filter
// Self-checking bench for the 153-tap centered FIR. A scoreboard class keeps
// its own tap store, sample history and push count. It predicts every output
// of an accepted push and checks each output item against the oldest
// prediction. Directed frames exercise the frame length extremes, a length
// change within a frame and ignored tap writes. Random frames, tap retunes
// and noise follow, under three idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_bandpass_fir_filter;

   localparam int TAPS         = bpf_pkg::TAPS;
   localparam int LAG          = bpf_pkg::LAG;
   localparam int RUN_LIMIT    = 2_000_000;
   localparam int DRAIN_WAIT   = TAPS + 20;
   localparam int RANDOM_ITEMS = 950;
   localparam int COUNT_TOP    = int'(bpf_pkg::CNT_MAX);
   localparam int MAX_REPORTS  = 50;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic signed [15:0] req_sample_in;
   logic [7:0]         req_coef_index;
   logic signed [15:0] req_coef_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_sample_out;
   logic [15:0]        rsp_out_index;
   logic               rsp_frame_last;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off;
   int items_sent;
   int cycle_count;

   typedef struct {
      logic [15:0] value;
      logic [15:0] pos;
      logic        is_last;
   } filter_point_type;

   class bandpass_scoreboard;
      shortint          coef_store[TAPS];
      shortint          history[TAPS];
      int unsigned      pushed;
      int unsigned      frame_len;
      filter_point_type expected_outputs[$];
      int               errors;

      function new();
         foreach (coef_store[i]) coef_store[i] = 0;
         foreach (history[i]) history[i] = 0;
         pushed    = 0;
         frame_len = bpf_pkg::FRAME_LEN_RST;
         errors    = 0;
      endfunction

      function void write_frame_length(logic [15:0] v);
         frame_len = v;
      endfunction

      // 32-bit wrapping sum of the signed products, newest sample on the last tap
      function bit [31:0] tap_sum();
         bit [31:0] acc;
         int        j;
         acc = 0;
         for (j = 0; j < TAPS; j++)
            acc += 32'(int'(history[j]) * int'(coef_store[TAPS-1-j]));
         return acc;
      endfunction

      function void note_item(bpf_pkg::func_type f, logic [15:0] smp, logic [7:0] ci,
                              logic [15:0] cv);
         int unsigned      pos;
         bit [31:0]        acc;
         filter_point_type fp;
         int               j;
         if (f == bpf_pkg::FUNC_COEF) begin
            if (ci < TAPS) coef_store[ci] = cv;
         end else if (f == bpf_pkg::FUNC_START) begin
            foreach (history[i]) history[i] = 0;
            pushed = 0;
         end else begin
            for (j = TAPS - 1; j > 0; j--) history[j] = history[j-1];
            history[0] = (f == bpf_pkg::FUNC_SAMPLE) ? smp : 16'h0000;
            if (pushed < COUNT_TOP) pushed++;
            if (pushed > LAG) begin
               pos = pushed - LAG - 1;
               if (pos < frame_len) begin
                  acc        = tap_sum();
                  fp.value   = acc[31:16];
                  fp.pos     = pos[15:0];
                  fp.is_last = (pos + 1 == frame_len);
                  expected_outputs.push_back(fp);
               end
            end
         end
      endfunction

      task flag_error(string msg);
         if (errors < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_output(logic [15:0] value, logic [15:0] pos, logic is_last);
         filter_point_type fp;
         if (expected_outputs.size() == 0) begin
            flag_error($sformatf("output at index %0d with none expected", pos));
         end else begin
            fp = expected_outputs.pop_front();
            if (value !== fp.value)
               flag_error($sformatf("output %0d: sample %h, expected %h",
                                    fp.pos, value, fp.value));
            if (pos !== fp.pos)
               flag_error($sformatf("output index %0d, expected %0d", pos, fp.pos));
            if (is_last !== fp.is_last)
               flag_error($sformatf("output %0d: frame_last %b, expected %b",
                                    fp.pos, is_last, fp.is_last));
         end
      endtask
   endclass

   bandpass_scoreboard sb;

   bandpass_fir_filter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_out_index  (rsp_out_index),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL bandpass_fir_filter");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_stall = 1'b1;
            hold_off--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Check outputs before noting inputs of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_output(rsp_sample_out, rsp_out_index, rsp_frame_last);
         if (req_valid && !req_stall)
            sb.note_item(bpf_pkg::func_type'(req_func), req_sample_in, req_coef_index,
                         req_coef_value);
         if (csr_wr_en) sb.write_frame_length(csr_wr_data);
      end
   end

   // Entered and left at a falling edge
   task automatic send_item(bpf_pkg::func_type f, logic [15:0] smp, logic [7:0] ci,
                            logic [15:0] cv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      = 1'b0;
         req_func       = 2'($urandom_range(3));
         req_sample_in  = 16'($urandom);
         req_coef_index = 8'($urandom);
         req_coef_value = 16'($urandom);
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_func       = f;
      req_sample_in  = smp;
      req_coef_index = ci;
      req_coef_value = cv;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_push();
      logic [15:0] smp;
      case ($urandom_range(15))
         0:       smp = 16'h8000;
         1:       smp = 16'h7FFF;
         2:       smp = 16'h0000;
         default: smp = 16'($urandom);
      endcase
      if ($urandom_range(3) == 0)
         send_item(bpf_pkg::FUNC_PAD, 16'($urandom), 8'($urandom), 16'($urandom));
      else
         send_item(bpf_pkg::FUNC_SAMPLE, smp, 8'($urandom), 16'($urandom));
   endtask

   // Hold until every predicted output is out, then let the block settle
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.expected_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic set_frame_length(logic [15:0] v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      csr_wr_data = 16'($urandom);
   endtask

   task automatic run_frame();
      int len;
      int pushes;
      int split_at;
      int k;
      if ($urandom_range(1) == 0) begin
         wait_idle();
         case ($urandom_range(15))
            0:       set_frame_length(16'd0);
            1:       set_frame_length(16'd1);
            2:       set_frame_length(16'hFFFF);
            3:       set_frame_length(bpf_pkg::FRAME_LEN_RST);
            default: set_frame_length(16'($urandom_range(2, 30)));
         endcase
      end
      len    = sb.frame_len;
      pushes = LAG + ((len > 40) ? 30 : len) + $urandom_range(3);
      // cut some frames short so a new start lands mid-frame
      if ($urandom_range(7) == 0) pushes = $urandom_range(1, pushes);
      split_at = ($urandom_range(3) == 0) ? $urandom_range(LAG, pushes) : -1;
      send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom), 16'($urandom));
      for (k = 0; k < pushes; k++) begin
         if (k == split_at) begin
            wait_idle();
            set_frame_length(16'($urandom_range(1, 40)));
         end
         // retune a tap now and then, sometimes out of range
         if ($urandom_range(15) == 0)
            send_item(bpf_pkg::FUNC_COEF, 16'($urandom), 8'($urandom), 16'($urandom));
         send_push();
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 6))
            send_item(bpf_pkg::func_type'($urandom_range(3)), 16'($urandom),
                      8'($urandom), 16'($urandom));
   endtask

   initial begin
      int          i;
      int          base;
      int          phase;
      bit          held;
      logic [15:0] cv;
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = bpf_pkg::FUNC_COEF;
      req_sample_in  = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      send_idle_pct  = 14;
      recv_stall_pct = 82;
      hold_off       = 0;
      items_sent     = 0;
      held           = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Load every tap before any output reads the store
      for (i = 0; i < TAPS; i++) begin
         cv = (i == 0) ? 16'h8000 : (i == TAPS - 1) ? 16'h7FFF : 16'($urandom);
         send_item(bpf_pkg::FUNC_COEF, 16'($urandom), 8'(i), cv);
      end
      send_item(bpf_pkg::FUNC_COEF, 16'($urandom), 8'(TAPS), 16'h7FFF);
      send_item(bpf_pkg::FUNC_COEF, 16'($urandom), 8'hFF, 16'h8000);

      // Reset frame length, extreme samples and a pad
      send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom), 16'($urandom));
      repeat (LAG) send_push();
      send_item(bpf_pkg::FUNC_SAMPLE, 16'h7FFF, 8'($urandom), 16'($urandom));
      send_item(bpf_pkg::FUNC_SAMPLE, 16'h8000, 8'($urandom), 16'($urandom));
      send_item(bpf_pkg::FUNC_PAD, 16'hFFFF, 8'($urandom), 16'($urandom));

      // Shrink the frame while it runs: index 3 becomes the last
      wait_idle();
      set_frame_length(16'd4);
      repeat (3) send_push();

      wait_idle();
      set_frame_length(16'd0);
      send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom), 16'($urandom));
      repeat (LAG + 4) send_push();

      wait_idle();
      set_frame_length(16'd1);
      send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom), 16'($urandom));
      repeat (LAG + 3) send_push();

      wait_idle();
      set_frame_length(16'hFFFF);
      send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom), 16'($urandom));
      repeat (LAG + 2) send_push();

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         phase = (items_sent - base) * 3 / RANDOM_ITEMS;
         if (phase == 0) begin
            send_idle_pct  = 14;
            recv_stall_pct = 82;
         end else if (phase == 1) begin
            send_idle_pct  = 82;
            recv_stall_pct = 14;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            if (!held) begin
               // block the output for a long stretch while pushes keep coming
               held = 1'b1;
               wait_idle();
               set_frame_length(16'd20);
               hold_off = 2000;
               send_item(bpf_pkg::FUNC_START, 16'($urandom), 8'($urandom),
                         16'($urandom));
               repeat (LAG + 12) send_push();
            end
         end
         run_frame();
      end

      wait_idle();
      if (sb.errors == 0)
         $display("PASS bandpass_fir_filter");
      else
         $display("FAIL bandpass_fir_filter");
      $finish;
   end

endmodule

@@ sim.f @@
src/bpf_pkg.sv
src/bpf_cell.sv
src/bpf_mac.sv
src/bandpass_fir_filter.sv
src/bpf_checker.sv
tb/tb_bandpass_fir_filter.sv
